// ----- src/nkst_pkg.sv -----
// Shared types, codes and helpers for the name-keyed session table.
// Used by name_keyed_session_table.sv; no dependencies.
package nkst_pkg;

  localparam int unsigned EntriesDef = 128;
  localparam int unsigned NameBytes  = 19;
  localparam int unsigned KeyAW      = 64;
  localparam int unsigned KeyBW      = 64;
  localparam int unsigned KeyCW      = 24;
  localparam int unsigned KeyW       = KeyAW + KeyBW + KeyCW;
  localparam int unsigned SockW      = 16;
  localparam int unsigned PosW       = 7;
  localparam int unsigned TotalW     = 8;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  // One stored row: name then socket.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SockW-1:0] sock;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Clear every byte after the first zero byte of the name.
  function automatic logic [KeyW-1:0] canon_name(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            ended;
    r     = k;
    ended = 1'b0;
    for (int i = 0; i < NameBytes; i++) begin
      if (ended) begin
        r[i*8 +: 8] = 8'h00;
      end else if (k[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/name_keyed_session_table.sv -----
// Name-keyed session table: insertion-ordered list of (name, socket) pairs.
// Add and the unused mode go straight to the result; find scans the rows in order
// until a hit or the end; remove scans the same way, then on a hit shifts every
// later row down to close the gap. Output stalls delay the result register load.
// One item at a time: the next item is accepted in the cycle after the load.
// Reset clears count and control; no RAM clearing.
module name_keyed_session_table #(
  parameter int unsigned ENTRIES = nkst_pkg::EntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                mode_i,
  input  logic [nkst_pkg::KeyAW-1:0] name_a_i,
  input  logic [nkst_pkg::KeyBW-1:0] name_b_i,
  input  logic [nkst_pkg::KeyCW-1:0] name_c_i,
  input  logic [nkst_pkg::SockW-1:0] socket_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [nkst_pkg::PosW-1:0]  position_o,
  output logic [nkst_pkg::SockW-1:0] socket_out_o,
  output logic [nkst_pkg::TotalW-1:0] entry_total_o
);

  import nkst_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  logic [KeyW-1:0]  key_q, key_d;
  mode_e            mode_q, mode_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    cmp_q, cmp_d;
  logic [CW-1:0]    wr_q, wr_d;
  status_e          res_status_q, res_status_d;
  logic [CW-1:0]    res_pos_q, res_pos_d;
  logic [SockW-1:0] res_sock_q, res_sock_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic [PosW-1:0]  out_pos_q;
  logic [SockW-1:0] out_sock_q;
  logic [TotalW-1:0] out_total_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;

  logic [KeyW-1:0]  in_key;
  logic             accept;
  logic             match;
  logic             more;
  logic             table_full;
  logic             out_load;
  logic [CW+PosW-1:0]   pos_ext;
  logic [CW+TotalW-1:0] total_ext;

  assign in_key     = canon_name({name_c_i, name_b_i, name_a_i});
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign match      = pend_q && (ram_rdata.key == key_q);
  assign more       = (issue_q < count_q);
  assign table_full = (count_q == CW'(ENTRIES));
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  nkst_ram #(
    .Width (EntryW),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_FIND || mode_i == MODE_REMOVE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = (mode_q == MODE_REMOVE) ? ST_SHIFT : ST_RESP;
        end else if (!more) begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (!more && !pend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    key_d        = key_q;
    mode_d       = mode_q;
    count_d      = count_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    cmp_d        = cmp_q;
    wr_d         = wr_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_sock_d   = res_sock_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = '{key: in_key, sock: socket_in_i};
    ram_raddr    = issue_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d        = in_key;
          mode_d       = mode_e'(mode_i);
          issue_d      = '0;
          res_status_d = STATUS_OK;
          res_pos_d    = '0;
          res_sock_d   = '0;
          case (mode_i)
            MODE_ADD: begin
              if (table_full) begin
                res_status_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                res_pos_d = count_q;
                count_d   = count_q + CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Keep one read in flight; compare the previous beat's row.
        if (more) begin
          issue_d = issue_q + CW'(1);
          pend_d  = 1'b1;
          cmp_d   = issue_q;
        end
        if (match) begin
          pend_d       = 1'b0;
          res_status_d = STATUS_OK;
          res_pos_d    = cmp_q;
          res_sock_d   = ram_rdata.sock;
          issue_d      = cmp_q + CW'(1);
          wr_d         = cmp_q;
        end else if (!more) begin
          res_status_d = STATUS_MISSING;
          res_pos_d    = '0;
        end
      end
      ST_SHIFT: begin
        // Read row i + 1, write it back to row i a beat later.
        if (more) begin
          issue_d = issue_q + CW'(1);
          pend_d  = 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          ram_wdata = ram_rdata;
          wr_d      = wr_q + CW'(1);
        end
        if (!more && !pend_q) begin
          count_d = count_q - CW'(1);
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  assign pos_ext   = {{PosW{1'b0}}, res_pos_q};
  assign total_ext = {{TotalW{1'b0}}, count_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    mode_q       <= mode_d;
    cmp_q        <= cmp_d;
    wr_q         <= wr_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_sock_q   <= res_sock_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= pos_ext[PosW-1:0];
      out_sock_q   <= res_sock_q;
      out_total_q  <= total_ext[TotalW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign socket_out_o  = out_sock_q;
  assign entry_total_o = out_total_q;

endmodule

// ----- src/nkst_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nkst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
